### rtl/cpc_pkg.sv
// shared types, constants and arctangent table for the polar/rectangular converter
package cpc_pkg;

   // field widths
   localparam int IN_WIDTH        = 16;
   localparam int OUT_WIDTH       = 17;

   // working formats: coordinates scaled by 2^14, angle in q30 radians
   localparam int GUARD_BITS      = 14;
   localparam int ANGLE_IN_SHIFT  = 17;
   localparam int ANGLE_OUT_SHIFT = 17;
   localparam int XY_WIDTH        = 34;
   localparam int Z_WIDTH         = 35;

   // gain correction multiplier
   localparam int MULT_WIDTH      = 32;
   localparam int GAIN_WIDTH      = 31;
   localparam int PROD_WIDTH      = MULT_WIDTH + GAIN_WIDTH;
   localparam int ROUND_SHIFT     = 44;

   localparam int ATAN_LEN        = 24;
   localparam int ATAN_IDX_WIDTH  = 5;

   localparam logic signed [Z_WIDTH-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [Z_WIDTH-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [Z_WIDTH-1:0] ANGLE_BIAS  =
      {{(Z_WIDTH-ANGLE_OUT_SHIFT){1'b0}}, 1'b1, {(ANGLE_OUT_SHIFT-1){1'b0}}};

   localparam logic signed [GAIN_WIDTH-1:0] INV_GAIN_Q30 = 31'sd652032874;
   localparam logic signed [PROD_WIDTH:0]   ROUND_BIAS   =
      {{(PROD_WIDTH+1-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}};

   localparam logic signed [OUT_WIDTH-1:0] OUT_LIMIT = 17'sd46341;
   localparam logic signed [OUT_WIDTH-1:0] PI_Q13    = 17'sd25736;

   typedef enum logic {
      MODE_RECT_TO_POLAR = 1'b0,
      MODE_POLAR_TO_RECT = 1'b1
   } conv_mode_type;

   typedef struct packed {
      conv_mode_type                mode;
      logic                         origin;
      logic                         flip;
      logic signed [XY_WIDTH-1:0]   x;
      logic signed [XY_WIDTH-1:0]   y;
      logic signed [Z_WIDTH-1:0]    z;
   } cordic_data_type;

   // atan(2^-i) in q30, truncated
   function automatic logic signed [Z_WIDTH-1:0] atan_q30(input logic [ATAN_IDX_WIDTH-1:0] idx);
      logic signed [Z_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 35'sd843314856;
         5'd1:    val = 35'sd497837829;
         5'd2:    val = 35'sd263043836;
         5'd3:    val = 35'sd133524134;
         5'd4:    val = 35'sd67021686;
         5'd5:    val = 35'sd33543515;
         5'd6:    val = 35'sd16775850;
         5'd7:    val = 35'sd8388437;
         5'd8:    val = 35'sd4194282;
         5'd9:    val = 35'sd2097149;
         5'd10:   val = 35'sd1048575;
         5'd11:   val = 35'sd524287;
         5'd12:   val = 35'sd262143;
         5'd13:   val = 35'sd131071;
         5'd14:   val = 35'sd65535;
         5'd15:   val = 35'sd32767;
         5'd16:   val = 35'sd16383;
         5'd17:   val = 35'sd8191;
         5'd18:   val = 35'sd4095;
         5'd19:   val = 35'sd2047;
         5'd20:   val = 35'sd1023;
         5'd21:   val = 35'sd511;
         5'd22:   val = 35'sd255;
         5'd23:   val = 35'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/cpc_pre.sv
// input conditioning stage: scaling, quadrant pre-rotation and origin detect
module cpc_pre
   import cpc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  conv_mode_type               in_mode,
   input  logic signed [IN_WIDTH-1:0]  in_a,
   input  logic signed [IN_WIDTH-1:0]  in_b,
   output logic                        out_valid,
   input  logic                        out_ready,
   output cordic_data_type             out_data
);

   logic                       valid_ff;
   cordic_data_type            data_ff;
   cordic_data_type            data_in;
   logic signed [XY_WIDTH-1:0] a_scaled;
   logic signed [XY_WIDTH-1:0] b_scaled;
   logic signed [Z_WIDTH-1:0]  b_angle;

   assign a_scaled = {{(XY_WIDTH-IN_WIDTH-GUARD_BITS){in_a[IN_WIDTH-1]}}, in_a,
                      {GUARD_BITS{1'b0}}};
   assign b_scaled = {{(XY_WIDTH-IN_WIDTH-GUARD_BITS){in_b[IN_WIDTH-1]}}, in_b,
                      {GUARD_BITS{1'b0}}};
   assign b_angle  = {{(Z_WIDTH-IN_WIDTH-ANGLE_IN_SHIFT){in_b[IN_WIDTH-1]}}, in_b,
                      {ANGLE_IN_SHIFT{1'b0}}};

   always_comb begin
      data_in.mode   = in_mode;
      data_in.origin = 1'b0;
      data_in.flip   = 1'b0;
      data_in.x      = a_scaled;
      data_in.y      = b_scaled;
      data_in.z      = '0;
      if (in_mode == MODE_RECT_TO_POLAR) begin
         data_in.origin = (in_a == '0) && (in_b == '0);
         // left half plane: mirror through the origin and start at +-pi
         if (in_a < 0) begin
            data_in.x = -a_scaled;
            data_in.y = -b_scaled;
            data_in.z = (in_b >= 0) ? PI_Q30 : -PI_Q30;
         end
      end else begin
         data_in.y = '0;
         data_in.z = b_angle;
         // fold angles beyond +-pi/2, negate the result later
         if (b_angle > HALF_PI_Q30) begin
            data_in.z    = b_angle - PI_Q30;
            data_in.flip = 1'b1;
         end else if (b_angle < -HALF_PI_Q30) begin
            data_in.z    = b_angle + PI_Q30;
            data_in.flip = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/cpc_stage.sv
// one cordic micro-rotation with its pipeline register
module cpc_stage
   import cpc_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_data_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output cordic_data_type out_data
);

   logic                       valid_ff;
   cordic_data_type            data_ff;
   cordic_data_type            data_in;
   logic signed [XY_WIDTH-1:0] dx;
   logic signed [XY_WIDTH-1:0] dy;
   logic signed [Z_WIDTH-1:0]  step_angle;
   logic                       turn_pos;

   assign dx         = in_data.y >>> SHIFT;
   assign dy         = in_data.x >>> SHIFT;
   assign step_angle = atan_q30(ATAN_IDX_WIDTH'(SHIFT));

   // rotation drives z to zero, vectoring drives y to zero
   assign turn_pos = (in_data.mode == MODE_POLAR_TO_RECT) ? (in_data.z >= 0)
                                                          : (in_data.y < 0);

   always_comb begin
      data_in = in_data;
      if (turn_pos) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - step_angle;
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + step_angle;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/cpc_post.sv
// gain correction multiply, rounding, saturation and output register
module cpc_post
   import cpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  cordic_data_type              in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [OUT_WIDTH-1:0]  out_a,
   output logic signed [OUT_WIDTH-1:0]  out_b
);

   function automatic logic signed [OUT_WIDTH-1:0] unscale(
      input logic signed [PROD_WIDTH-1:0] prod);
      logic signed [PROD_WIDTH:0] sum;
      logic signed [PROD_WIDTH:0] shifted;
      logic signed [OUT_WIDTH-1:0] val;
      sum     = prod + ROUND_BIAS;
      shifted = sum >>> ROUND_SHIFT;
      if (shifted > OUT_LIMIT) begin
         val = OUT_LIMIT;
      end else if (shifted < -OUT_LIMIT) begin
         val = -OUT_LIMIT;
      end else begin
         val = shifted[OUT_WIDTH-1:0];
      end
      return val;
   endfunction

   // multiply stage
   logic                          mul_valid_ff;
   logic                          mul_ready;
   conv_mode_type                 mode_ff;
   logic                          origin_ff;
   logic signed [PROD_WIDTH-1:0]  prod_x_ff;
   logic signed [PROD_WIDTH-1:0]  prod_y_ff;
   logic signed [OUT_WIDTH-1:0]   angle_ff;
   logic signed [PROD_WIDTH-1:0]  prod_x_in;
   logic signed [PROD_WIDTH-1:0]  prod_y_in;
   logic signed [OUT_WIDTH-1:0]   angle_in;
   logic signed [XY_WIDTH-1:0]    x_sel;
   logic signed [XY_WIDTH-1:0]    y_sel;
   logic signed [MULT_WIDTH-1:0]  x_mul;
   logic signed [MULT_WIDTH-1:0]  y_mul;
   logic signed [Z_WIDTH-1:0]     z_rounded;
   logic signed [Z_WIDTH-1:0]     z_shifted;

   // output stage
   logic                          out_valid_ff;
   logic                          out_stage_ready;
   logic signed [OUT_WIDTH-1:0]   result_a_ff;
   logic signed [OUT_WIDTH-1:0]   result_b_ff;
   logic signed [OUT_WIDTH-1:0]   result_a_in;
   logic signed [OUT_WIDTH-1:0]   result_b_in;

   assign x_sel = in_data.flip ? -in_data.x : in_data.x;
   assign y_sel = in_data.flip ? -in_data.y : in_data.y;
   assign x_mul = x_sel[MULT_WIDTH-1:0];
   assign y_mul = y_sel[MULT_WIDTH-1:0];

   assign prod_x_in = x_mul * INV_GAIN_Q30;
   assign prod_y_in = y_mul * INV_GAIN_Q30;

   // q30 angle to q13, round half up, clamp to +-pi
   assign z_rounded = in_data.z + ANGLE_BIAS;
   assign z_shifted = z_rounded >>> ANGLE_OUT_SHIFT;

   always_comb begin
      if (z_shifted > PI_Q13) begin
         angle_in = PI_Q13;
      end else if (z_shifted < -PI_Q13) begin
         angle_in = -PI_Q13;
      end else begin
         angle_in = z_shifted[OUT_WIDTH-1:0];
      end
   end

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign mul_ready       = !mul_valid_ff || out_stage_ready;
   assign in_ready        = mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mode_ff   <= in_data.mode;
         origin_ff <= in_data.origin;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         angle_ff  <= angle_in;
      end
   end

   always_comb begin
      if (origin_ff) begin
         result_a_in = '0;
         result_b_in = '0;
      end else if (mode_ff == MODE_RECT_TO_POLAR) begin
         result_a_in = unscale(prod_x_ff);
         result_b_in = angle_ff;
      end else begin
         result_a_in = unscale(prod_x_ff);
         result_b_in = unscale(prod_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_stage_ready) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_stage_ready && mul_valid_ff) begin
         result_a_ff <= result_a_in;
         result_b_ff <= result_b_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_a     = result_a_ff;
   assign out_b     = result_b_ff;

endmodule

### rtl/polar_rect_converter.sv
// top level of the pipelined cordic polar/rectangular converter
// Converts one point per request between rectangular and polar form. With
// req_type 0 the point (x, y) gives its magnitude and its full-quadrant angle
// in [-pi, pi]; the origin gives magnitude 0 and angle 0. With req_type 1 the
// radius and angle give r*cos and r*sin; any angle is taken and a negative
// radius gives the opposite point. Coordinates carry 8 fraction bits, angles
// are radians with 13 fraction bits, and results saturate at +-46341 (angles at +-pi).
// The datapath is a fully unrolled cordic: one conditioning stage, one
// register stage per iteration, a gain-correction multiply stage and an
// output register. A new request is taken every clock cycle unless a stalled
// response backs up the pipeline. Every stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so a stalled
// result only backs up as far as needed.
module polar_rect_converter
   import cpc_pkg::*;
#(
   parameter int ITERATIONS = 16
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic signed [IN_WIDTH-1:0]   req_first_operand,
   input  logic signed [IN_WIDTH-1:0]   req_second_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_WIDTH-1:0]  rsp_result_a,
   output logic signed [OUT_WIDTH-1:0]  rsp_result_b
);

   // pipe link k feeds iteration stage k, link ITERATIONS feeds the multiplier
   logic            link_valid [ITERATIONS+1];
   logic            link_ready [ITERATIONS+1];
   cordic_data_type link_data  [ITERATIONS+1];

   // scale inputs, fold quadrants, flag the origin
   cpc_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mode   (conv_mode_type'(req_type)),
      .in_a      (req_first_operand),
      .in_b      (req_second_operand),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // one micro-rotation per stage, shift and table entry fixed per stage
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      cpc_stage #(
         .SHIFT (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // remove cordic gain, round, saturate, hold the result
   cpc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[ITERATIONS]),
      .in_ready  (link_ready[ITERATIONS]),
      .in_data   (link_data[ITERATIONS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_a     (rsp_result_a),
      .out_b     (rsp_result_b)
   );

endmodule

### rtl/cpc_checker.sv
// port-level checks for the polar/rectangular converter and their bind
module cpc_checker
   import cpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [OUT_WIDTH-1:0]  rsp_result_a,
   input  logic signed [OUT_WIDTH-1:0]  rsp_result_b
);

   // a response that is not taken stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an empty output register means every stage can move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // results never leave the saturation range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_a <= OUT_LIMIT && rsp_result_a >= -OUT_LIMIT &&
                    rsp_result_b <= OUT_LIMIT && rsp_result_b >= -OUT_LIMIT)
      else $error("result outside saturation range");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind polar_rect_converter cpc_checker u_checker (.*);

### test/polar_rect_converter_tb.sv
// testbench for the pipelined cordic polar/rectangular converter
`timescale 1ns / 1ps

module testbench;
   import cpc_pkg::*;

   // iteration count of the datapath under test
   localparam int ITER         = 16;
   localparam int DRAIN_CYCLES = ITER + 8;
   // receiver hold-off long enough to back the whole pipeline up
   localparam int HOLD_CYCLES  = 80;
   localparam int STALL_LIMIT  = 2000;

   // working formats: coordinates scaled by 2^14, angles in q30 radians
   localparam longint COORD_SCALE   = 64'sd16384;
   localparam longint ANGLE_SCALE   = 64'sd131072;
   localparam longint PI_RAD_Q30    = 64'sd3373259426;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint PI_RAD_Q13    = 64'sd25736;
   localparam longint GAIN_INV_Q30  = 64'sd652032874;
   localparam longint RESULT_LIMIT  = 64'sd46341;

   // atan(2^-i) in q30, truncated
   localparam longint ARCTAN_Q30 [24] = '{
      843314856, 497837829, 263043836, 133524134,
      67021686, 33543515, 16775850, 8388437,
      4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047,
      1023, 511, 255, 127
   };

   localparam logic signed [IN_WIDTH-1:0] EDGE_OPERANDS [7] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sd12868, -16'sd12868
   };

   typedef struct packed {
      conv_mode_type                 kind;
      logic signed [IN_WIDTH-1:0]    first_op;
      logic signed [IN_WIDTH-1:0]    second_op;
      logic signed [OUT_WIDTH-1:0]   result_a;
      logic signed [OUT_WIDTH-1:0]   result_b;
   } conv_result_type;

   logic                         clock;
   logic                         reset              = 1'b1;
   logic                         req_valid          = 1'b0;
   logic                         req_ready;
   logic                         req_type           = 1'b0;
   logic signed [IN_WIDTH-1:0]   req_first_operand  = '0;
   logic signed [IN_WIDTH-1:0]   req_second_operand = '0;
   logic                         rsp_valid;
   logic                         rsp_ready          = 1'b0;
   logic signed [OUT_WIDTH-1:0]  rsp_result_a;
   logic signed [OUT_WIDTH-1:0]  rsp_result_b;

   // predicted conversions, oldest first
   conv_result_type expected_results [$];
   int              mismatch_count = 0;

   // idling controls for the sender and the receiver
   bit send_idling        = 1'b1;
   bit drain_idling       = 1'b1;
   bit drain_hold_request = 1'b0;

   polar_rect_converter #(.ITERATIONS(ITER)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_a       (rsp_result_a),
      .rsp_result_b       (rsp_result_b)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   function automatic longint saturate(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // divide out the cordic gain, round half up
   function automatic longint remove_gain(input longint v);
      return (v * GAIN_INV_Q30 + (64'sd1 <<< 43)) >>> 44;
   endfunction

   function automatic conv_result_type convert_point(input conv_mode_type kind,
         input logic signed [IN_WIDTH-1:0] first_op,
         input logic signed [IN_WIDTH-1:0] second_op);
      conv_result_type res;
      longint          a, b, x, y, z, dx, dy, ra, rb;
      logic            flip;
      a = first_op;
      b = second_op;
      z = 0;
      flip = 1'b0;
      res.kind = kind;
      res.first_op = first_op;
      res.second_op = second_op;
      if (kind == MODE_RECT_TO_POLAR) begin
         if (a == 0 && b == 0) begin
            // origin: magnitude and angle both zero
            ra = 0;
            rb = 0;
         end else begin
            x = a * COORD_SCALE;
            y = b * COORD_SCALE;
            // left half plane: rotate by pi first
            if (a < 0) begin
               x = -x;
               y = -y;
               z = (b >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
            end
            // vectoring: drive y to zero, accumulate the angle
            for (int i = 0; i < ITER; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x += dx;
                  y -= dy;
                  z += ARCTAN_Q30[i];
               end else begin
                  x -= dx;
                  y += dy;
                  z -= ARCTAN_Q30[i];
               end
            end
            ra = remove_gain(x);
            rb = saturate((z + 64'sd65536) >>> 17, PI_RAD_Q13);
         end
      end else begin
         z = b * ANGLE_SCALE;
         // angles past +-pi/2 move by pi and the point is negated afterwards
         if (z > HALF_PI_Q30_L) begin
            z -= PI_RAD_Q30;
            flip = 1'b1;
         end else if (z < -HALF_PI_Q30_L) begin
            z += PI_RAD_Q30;
            flip = 1'b1;
         end
         x = a * COORD_SCALE;
         y = 0;
         // rotation: drive the residual angle to zero
         for (int i = 0; i < ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ARCTAN_Q30[i];
            end else begin
               x += dx;
               y -= dy;
               z += ARCTAN_Q30[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         ra = remove_gain(x);
         rb = remove_gain(y);
      end
      res.result_a = saturate(ra, RESULT_LIMIT);
      res.result_b = saturate(rb, RESULT_LIMIT);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // offer one request, hold it until taken, then record its prediction
   task automatic offer_point(input conv_mode_type kind,
         input logic signed [IN_WIDTH-1:0] first_op,
         input logic signed [IN_WIDTH-1:0] second_op);
      while (send_idling && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_first_operand  <= first_op;
      req_second_operand <= second_op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(convert_point(kind, first_op, second_op));
   endtask

   // mostly full-range values, with extremes and small magnitudes mixed in
   function automatic logic signed [IN_WIDTH-1:0] pick_operand();
      logic [31:0] draw;
      draw = $urandom();
      case ($urandom_range(9))
         0:       return EDGE_OPERANDS[$urandom_range(6)];
         1, 2:    return {{9{draw[6]}}, draw[6:0]};
         default: return draw[15:0];
      endcase
   endfunction

   task automatic offer_random_point();
      conv_mode_type kind;
      kind = conv_mode_type'($urandom_range(1));
      offer_point(kind, pick_operand(), pick_operand());
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver ready: random idling, or a long hold-off on request
   initial begin : result_drain
      forever begin
         @(posedge clock);
         if (drain_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            drain_hold_request = 1'b0;
         end else if (drain_idling && $urandom_range(99) < 7) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted result with the oldest prediction
   initial begin : result_check
      conv_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result a=%0d b=%0d", $time,
                  rsp_result_a, rsp_result_b);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_a !== want.result_a) begin
                  mismatch_count++;
                  $display("%0t: result_a mismatch (type %0d, %0d, %0d) expected %0d actual %0d",
                     $time, want.kind, want.first_op, want.second_op,
                     want.result_a, rsp_result_a);
               end
               if (rsp_result_b !== want.result_b) begin
                  mismatch_count++;
                  $display("%0t: result_b mismatch (type %0d, %0d, %0d) expected %0d actual %0d",
                     $time, want.kind, want.first_op, want.second_op,
                     want.result_b, rsp_result_b);
               end
            end
         end
      end
   end

   // end the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("polar_rect_converter verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // origin, axes, quadrant edges, angle folding, negative radius, saturation
   task automatic test_corner_points();
      offer_point(MODE_RECT_TO_POLAR, 16'sd0, 16'sd0);
      offer_point(MODE_RECT_TO_POLAR, 16'sd32767, 16'sd0);
      offer_point(MODE_RECT_TO_POLAR, -16'sd32768, 16'sd0);
      offer_point(MODE_RECT_TO_POLAR, 16'sd0, 16'sd32767);
      offer_point(MODE_RECT_TO_POLAR, 16'sd0, -16'sd32768);
      offer_point(MODE_RECT_TO_POLAR, -16'sd32768, -16'sd32768);
      offer_point(MODE_RECT_TO_POLAR, 16'sd32767, 16'sd32767);
      offer_point(MODE_RECT_TO_POLAR, -16'sd32768, 16'sd32767);
      offer_point(MODE_RECT_TO_POLAR, -16'sd1, 16'sd0);
      offer_point(MODE_RECT_TO_POLAR, -16'sd1, -16'sd1);
      offer_point(MODE_RECT_TO_POLAR, 16'sd1, -16'sd1);
      offer_point(MODE_RECT_TO_POLAR, -16'sd256, 16'sd0);
      offer_point(MODE_RECT_TO_POLAR, 16'sd256, 16'sd256);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, 16'sd0);
      offer_point(MODE_POLAR_TO_RECT, -16'sd32768, 16'sd0);
      offer_point(MODE_POLAR_TO_RECT, 16'sd0, 16'sd12345);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, 16'sd12867);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, 16'sd12868);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, -16'sd12867);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, -16'sd12868);
      offer_point(MODE_POLAR_TO_RECT, 16'sd256, 16'sd25736);
      offer_point(MODE_POLAR_TO_RECT, -16'sd256, -16'sd25736);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, 16'sd32767);
      offer_point(MODE_POLAR_TO_RECT, -16'sd32768, -16'sd32768);
      offer_point(MODE_POLAR_TO_RECT, 16'sd32767, 16'sd6434);
      offer_point(MODE_POLAR_TO_RECT, -16'sd1, 16'sd16384);
   endtask

   // random requests with idling on both sides
   task automatic test_random_traffic(input int count);
      send_idling  = 1'b1;
      drain_idling = 1'b1;
      repeat (count) offer_random_point();
   endtask

   // receiver holds off while the sender keeps offering, pipeline backs up
   task automatic test_full_pipeline_stall();
      send_idling = 1'b0;
      drain_hold_request = 1'b1;
      repeat (150) offer_random_point();
      send_idling = 1'b1;
   endtask

   // short bursts, each followed by a pause until everything has come back
   task automatic test_drain_between_bursts();
      repeat (6) begin
         repeat ($urandom_range(60, 20)) offer_random_point();
         wait_until_drained();
      end
   endtask

   // long stretch with no idling on either side
   task automatic test_back_to_back_stream();
      send_idling  = 1'b0;
      drain_idling = 1'b0;
      repeat (300) offer_random_point();
      send_idling  = 1'b1;
      drain_idling = 1'b1;
   endtask

   initial begin : main_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_corner_points();
      test_random_traffic(400);
      test_full_pipeline_stall();
      test_drain_between_bursts();
      test_back_to_back_stream();
      test_random_traffic(100);
      wait_until_drained();
      // catch any stray result trailing the last prediction
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("polar_rect_converter verification clean");
      else
         $display("polar_rect_converter verification failed");
      $finish;
   end

endmodule
